>>> src/prf_pkg.sv
// prf_pkg: shared types and constants for the capture file record framer
// no dependencies; imported by every module of the block
`default_nettype none

package prf_pkg;

    localparam int DATA_W       = 8;
    localparam int WORD_W       = 32;
    localparam int REC_OFFSET_W = 48;
    localparam int HDR_CNT_W    = 5;
    localparam int CFG_INDEX_W  = 8;
    localparam int M_TDATA_W    = 128;
    localparam int M_TUSER_W    = 2;

    // tdata bit positions of the result fields
    localparam int TD_OFFSET_LO = 0;
    localparam int TD_TIME_LO   = TD_OFFSET_LO + REC_OFFSET_W;
    localparam int TD_LEN_LO    = TD_TIME_LO + WORD_W;
    localparam int TD_FIRST     = TD_LEN_LO + WORD_W;
    localparam int TD_BYTE_LO   = TD_FIRST + 1;
    localparam int TD_USED_W    = TD_BYTE_LO + DATA_W;

    localparam logic [HDR_CNT_W-1:0] GLOBAL_HDR_LEN = HDR_CNT_W'(24);
    localparam logic [HDR_CNT_W-1:0] RECORD_HDR_LEN = HDR_CNT_W'(16);
    localparam logic [HDR_CNT_W-1:0] MAGIC_LAST_POS = HDR_CNT_W'(3);
    localparam logic [HDR_CNT_W-1:0] TIME_END_POS   = HDR_CNT_W'(4);
    localparam logic [HDR_CNT_W-1:0] LEN_FIELD_POS  = HDR_CNT_W'(8);
    localparam logic [HDR_CNT_W-1:0] LEN_END_POS    = HDR_CNT_W'(12);

    localparam logic [WORD_W-1:0] MAGIC_NATIVE  = 32'ha1b2c3d4;
    localparam logic [WORD_W-1:0] MAGIC_SWAPPED = 32'hd4c3b2a1;

    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_ENABLE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_ENABLE = CFG_INDEX_W'(1);

    typedef enum logic [M_TUSER_W-1:0] {
        KIND_INDEX   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_GLOBAL  = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic index_enable;
        logic payload_enable;
    } cfg_t;

    typedef struct packed {
        kind_t                   kind;
        logic [REC_OFFSET_W-1:0] record_offset;
        logic [WORD_W-1:0]       arrival_second;
        logic [WORD_W-1:0]       capture_len;
        logic                    first_record;
        logic [DATA_W-1:0]       payload_byte;
        logic                    payload_last;
    } res_t;

    function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

>>> src/prf_parser.sv
// prf_parser: per-byte header and payload state machine of the framer
// depends on prf_pkg; produces at most one result per accepted beat
`default_nettype none

module prf_parser #(
    parameter int OFFSET_BITS = 48
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    input  wire logic [prf_pkg::DATA_W-1:0] in_byte,
    input  wire prf_pkg::cfg_t              cfg,
    output logic                            res_valid,
    output prf_pkg::res_t                   res
);
    import prf_pkg::*;

    phase_t                  phase_reg,    phase_next;
    logic [HDR_CNT_W-1:0]    count_reg,    count_next;
    logic [WORD_W-1:0]       magic_reg,    magic_next;
    logic                    swapped_reg,  swapped_next;
    logic [WORD_W-1:0]       time_reg,     time_next;
    logic [WORD_W-1:0]       length_reg,   length_next;
    logic [WORD_W-1:0]       remain_reg,   remain_next;
    logic [OFFSET_BITS-1:0]  offset_reg,   offset_next;
    logic [OFFSET_BITS-1:0]  rstart_reg,   rstart_next;
    logic                    seen_reg,     seen_next;
    logic [REC_OFFSET_W-1:0] rstart_out;

    generate
        if (OFFSET_BITS >= REC_OFFSET_W) begin : g_trunc
            assign rstart_out = rstart_reg[REC_OFFSET_W-1:0];
        end else begin : g_ext
            assign rstart_out = {{(REC_OFFSET_W-OFFSET_BITS){1'b0}}, rstart_reg};
        end
    endgenerate

    function automatic logic [WORD_W-1:0] magic_new_time(input logic [WORD_W-1:0] w,
                                                         input logic [DATA_W-1:0] b);
        return {b, w[WORD_W-1:DATA_W]};
    endfunction

    always_comb begin
        logic [WORD_W-1:0]    magic_new;
        logic [HDR_CNT_W-1:0] count_inc;
        logic [WORD_W-1:0]    len_fixed;
        logic [WORD_W-1:0]    time_fixed;

        magic_new  = {in_byte, magic_reg[WORD_W-1:DATA_W]};
        count_inc  = count_reg + HDR_CNT_W'(1);
        len_fixed  = swapped_reg ? byte_swap(length_reg) : length_reg;
        time_fixed = swapped_reg ? byte_swap(time_reg) : time_reg;

        phase_next   = phase_reg;
        count_next   = count_reg;
        magic_next   = magic_reg;
        swapped_next = swapped_reg;
        time_next    = time_reg;
        length_next  = length_reg;
        remain_next  = remain_reg;
        offset_next  = offset_reg + OFFSET_BITS'(1);
        rstart_next  = rstart_reg;
        seen_next    = seen_reg;
        res_valid    = 1'b0;
        res          = '0;

        unique case (phase_reg)
            PH_GLOBAL: begin
                if (count_reg < MAGIC_LAST_POS + HDR_CNT_W'(1)) begin
                    magic_next = magic_new;
                end
                if (count_reg == MAGIC_LAST_POS) begin
                    if (magic_new == MAGIC_SWAPPED) begin
                        swapped_next = 1'b1;
                    end else begin
                        swapped_next = 1'b0;
                        if (magic_new != MAGIC_NATIVE) begin
                            res_valid = 1'b1;
                            res.kind  = KIND_ERROR;
                        end
                    end
                end
                count_next = count_inc;
                if (count_inc >= GLOBAL_HDR_LEN) begin
                    count_next = '0;
                    phase_next = PH_HEADER;
                end
            end
            PH_PAYLOAD: begin
                if (cfg.payload_enable) begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_PAYLOAD;
                    res.payload_byte   = in_byte;
                    res.payload_last   = (remain_reg == WORD_W'(1));
                end
                remain_next = remain_reg - WORD_W'(1);
                if (remain_reg == WORD_W'(1)) begin
                    phase_next = PH_HEADER;
                end
            end
            default: begin
                if (count_reg == '0) begin
                    rstart_next = offset_reg;
                end
                if (count_reg < TIME_END_POS) begin
                    time_next = magic_new_time(time_reg, in_byte);
                end else if (count_reg >= LEN_FIELD_POS && count_reg < LEN_END_POS) begin
                    length_next = magic_new_time(length_reg, in_byte);
                end
                count_next = count_inc;
                if (count_inc >= RECORD_HDR_LEN) begin
                    count_next = '0;
                    if (cfg.index_enable) begin
                        res_valid          = 1'b1;
                        res.kind           = KIND_INDEX;
                        res.record_offset  = rstart_out;
                        res.arrival_second = time_fixed;
                        res.capture_len    = len_fixed;
                        res.first_record   = !seen_reg;
                    end
                    seen_next   = 1'b1;
                    remain_next = len_fixed;
                    phase_next  = (len_fixed != '0) ? PH_PAYLOAD : PH_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_GLOBAL;
            count_reg   <= '0;
            swapped_reg <= 1'b0;
            offset_reg  <= '0;
            seen_reg    <= 1'b0;
        end else if (in_valid) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            swapped_reg <= swapped_next;
            offset_reg  <= offset_next;
            seen_reg    <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            magic_reg  <= magic_next;
            time_reg   <= time_next;
            length_reg <= length_next;
            remain_reg <= remain_next;
            rstart_reg <= rstart_next;
        end
    end

endmodule

`default_nettype wire

>>> src/prf_skid.sv
// prf_skid: two-slot output buffer holding results for the master side
// depends on prf_pkg; decouples input ready from output stalls
`default_nettype none

module prf_skid (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire prf_pkg::res_t push_res,
    output logic               can_push,
    output logic               out_valid,
    output prf_pkg::res_t      out_res,
    input  wire logic          out_ready
);
    import prf_pkg::*;

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_reg <= push_res;
            end else begin
                skid_reg <= push_res;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/pcap_record_framer_top.sv
// pcap_record_framer_top: capture file record framer, one file byte per beat
// depends on prf_pkg, prf_parser and prf_skid
//
// Takes a capture file one byte per beat and emits bad-magic errors and, when enabled,
// one index entry per record header and each payload byte, with tlast on the final
// byte of a record. Every byte is processed by the parser state machine and its
// result lands in a two-slot output buffer in the next cycle,
// so the block sustains one input beat per clock; s_tready drops only while both
// output slots hold results that the master side has not taken. The config port
// is always ready and is meant to be written while the stream is idle; writes to
// unknown register indexes are dropped.
`default_nettype none

module pcap_record_framer_top #(
    parameter int OFFSET_BITS = 48
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [prf_pkg::DATA_W-1:0]       s_tdata,   // data_byte
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // record_offset, arrival_second, capture_len, first_record, payload_byte, zero pad
    output logic [prf_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic [prf_pkg::M_TUSER_W-1:0]         m_tuser,   // kind
    output logic                                  m_tlast,   // payload_last
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [prf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic                             cfg_data
);
    import prf_pkg::*;

    cfg_t cfg_reg;
    logic in_fire;
    logic res_valid;
    res_t res;
    res_t out_res;
    logic can_push;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_push;
    assign in_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.index_enable   <= 1'b1;
            cfg_reg.payload_enable <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_INDEX_ENABLE:   cfg_reg.index_enable   <= cfg_data;
                REG_PAYLOAD_ENABLE: cfg_reg.payload_enable <= cfg_data;
                default: ;
            endcase
        end
    end

    prf_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_fire),
        .in_byte   (s_tdata),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    prf_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire && res_valid),
        .push_res  (res),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {(M_TDATA_W-TD_USED_W)'(0), out_res.payload_byte, out_res.first_record,
                      out_res.capture_len, out_res.arrival_second, out_res.record_offset};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.payload_last;

endmodule

`default_nettype wire

>>> src/prf_checker.sv
// prf_checker: port-level checks on the framer result stream
// depends on prf_pkg; bound to pcap_record_framer_top below
`default_nettype none

module prf_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [prf_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [prf_pkg::M_TUSER_W-1:0]    m_tuser,
    input wire logic                             m_tlast
);
    import prf_pkg::*;

    // index fields stay clear on payload and error beats
    a_index_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_INDEX) |-> (m_tdata[TD_BYTE_LO-1:0] == '0))
        else $error("index fields set on a non-index beat");

    // payload fields stay clear on index and error beats
    a_payload_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_PAYLOAD) |->
            (!m_tlast && m_tdata[TD_USED_W-1:TD_BYTE_LO] == '0))
        else $error("payload fields set on a non-payload beat");

    // stalled beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result beat changed while stalled");

    // nothing offered right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind pcap_record_framer_top prf_checker u_prf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> sim/pcap_record_framer_top_test.sv
`timescale 1ns / 100ps
// pcap_record_framer_top_test: self-checking bench for the capture file record framer
// depends on prf_pkg and pcap_record_framer_top; streams one synthetic capture file
// through a random-idle driver and checks every output beat against a local predictor

module pcap_record_framer_top_test;

    import prf_pkg::*;

    typedef enum logic [1:0] {
        FILE_NATIVE,
        FILE_SWAPPED,
        FILE_BAD_MAGIC
    } file_form_t;

    localparam logic [CFG_INDEX_W-1:0] STRAY_INDEX = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] TOP_INDEX   = {CFG_INDEX_W{1'b1}};
    localparam int SETTLE_CYCLES = 4;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic                   cfg_data  = 1'b0;

    pcap_record_framer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("pcap_record_framer_top_test NOT OK");
        $finish;
    end

    // predictor state
    phase_t                  fr_phase      = PH_GLOBAL;
    logic [HDR_CNT_W-1:0]    fr_hdr_pos    = '0;
    logic [WORD_W-1:0]       fr_magic      = '0;
    logic [WORD_W-1:0]       fr_time       = '0;
    logic [WORD_W-1:0]       fr_len_word   = '0;
    logic [WORD_W-1:0]       fr_remaining  = '0;
    logic [REC_OFFSET_W-1:0] fr_offset     = '0;
    logic [REC_OFFSET_W-1:0] fr_rec_start  = '0;
    logic                    fr_swapped    = 1'b0;
    logic                    fr_seen_first = 1'b0;
    cfg_t                    fr_cfg        = '{index_enable: 1'b1, payload_enable: 1'b1};

    logic [DATA_W-1:0] file_image[$];
    logic [DATA_W-1:0] capture_bytes[$];
    res_t              due_results[$];
    logic              file_swapped = 1'b0;
    int                idle_pct     = 0;
    int                send_gap     = 0;
    int                hold_gap     = 0;
    int                mismatches   = 0;

    function automatic logic [WORD_W-1:0] fix_order(input logic [WORD_W-1:0] w);
        return fr_swapped ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
    endfunction

    function automatic void advance_framer(input logic [DATA_W-1:0] b);
        logic [WORD_W-1:0] rec_len;
        res_t              want;
        logic              emit;
        want = '0;
        emit = 1'b0;
        case (fr_phase)
            PH_GLOBAL: begin
                if (fr_hdr_pos <= MAGIC_LAST_POS) begin
                    fr_magic = {b, fr_magic[WORD_W-1:8]};
                    if (fr_hdr_pos == MAGIC_LAST_POS) begin
                        fr_swapped = (fr_magic == MAGIC_SWAPPED);
                        if (fr_magic != MAGIC_SWAPPED && fr_magic != MAGIC_NATIVE) begin
                            want.kind = KIND_ERROR;
                            emit = 1'b1;
                        end
                    end
                end
                fr_hdr_pos = fr_hdr_pos + 1'b1;
                if (fr_hdr_pos >= GLOBAL_HDR_LEN) begin
                    fr_hdr_pos = '0;
                    fr_phase = PH_HEADER;
                end
            end
            PH_PAYLOAD: begin
                if (fr_cfg.payload_enable) begin
                    want.kind = KIND_PAYLOAD;
                    want.payload_byte = b;
                    want.payload_last = (fr_remaining == 1);
                    emit = 1'b1;
                end
                fr_remaining = fr_remaining - 1'b1;
                if (fr_remaining == 0)
                    fr_phase = PH_HEADER;
            end
            default: begin
                if (fr_hdr_pos == '0)
                    fr_rec_start = fr_offset;
                if (fr_hdr_pos < TIME_END_POS)
                    fr_time = {b, fr_time[WORD_W-1:8]};
                else if (fr_hdr_pos >= LEN_FIELD_POS && fr_hdr_pos < LEN_END_POS)
                    fr_len_word = {b, fr_len_word[WORD_W-1:8]};
                fr_hdr_pos = fr_hdr_pos + 1'b1;
                if (fr_hdr_pos >= RECORD_HDR_LEN) begin
                    rec_len = fix_order(fr_len_word);
                    fr_hdr_pos = '0;
                    if (fr_cfg.index_enable) begin
                        want.kind = KIND_INDEX;
                        want.record_offset = fr_rec_start;
                        want.arrival_second = fix_order(fr_time);
                        want.capture_len = rec_len;
                        want.first_record = !fr_seen_first;
                        emit = 1'b1;
                    end
                    fr_seen_first = 1'b1;
                    fr_remaining = rec_len;
                    fr_phase = (rec_len != 0) ? PH_PAYLOAD : PH_HEADER;
                end
            end
        endcase
        fr_offset = fr_offset + 1'b1;
        if (emit)
            due_results.push_back(want);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_beat();
        res_t want;
        if (due_results.size() == 0) begin
            report_mismatch("beat with nothing due", 64'(m_tuser), 64'(0));
            return;
        end
        want = due_results.pop_front();
        if (m_tuser !== want.kind)
            report_mismatch("kind", 64'(m_tuser), 64'(want.kind));
        if (m_tdata[TD_OFFSET_LO +: REC_OFFSET_W] !== want.record_offset)
            report_mismatch("record_offset", 64'(m_tdata[TD_OFFSET_LO +: REC_OFFSET_W]),
                            64'(want.record_offset));
        if (m_tdata[TD_TIME_LO +: WORD_W] !== want.arrival_second)
            report_mismatch("arrival_second", 64'(m_tdata[TD_TIME_LO +: WORD_W]),
                            64'(want.arrival_second));
        if (m_tdata[TD_LEN_LO +: WORD_W] !== want.capture_len)
            report_mismatch("capture_len", 64'(m_tdata[TD_LEN_LO +: WORD_W]),
                            64'(want.capture_len));
        if (m_tdata[TD_FIRST] !== want.first_record)
            report_mismatch("first_record", 64'(m_tdata[TD_FIRST]), 64'(want.first_record));
        if (m_tdata[TD_BYTE_LO +: DATA_W] !== want.payload_byte)
            report_mismatch("payload_byte", 64'(m_tdata[TD_BYTE_LO +: DATA_W]),
                            64'(want.payload_byte));
        if (m_tlast !== want.payload_last)
            report_mismatch("payload_last", 64'(m_tlast), 64'(want.payload_last));
    endtask

    // byte driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                advance_framer(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (capture_bytes.size() != 0 && idle_pct != 0 &&
                             $urandom_range(99, 0) < idle_pct) begin
                    send_gap = $urandom_range(2, 0);
                    s_tvalid <= 1'b0;
                end else if (capture_bytes.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= capture_bytes.pop_front();
                end else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_beat();
            if (hold_gap != 0) begin
                hold_gap--;
                m_tready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
                hold_gap = $urandom_range(2, 0);
                m_tready <= 1'b0;
            end else
                m_tready <= 1'b1;
        end
    end

    task automatic push_word(input logic [WORD_W-1:0] w);
        if (file_swapped) begin
            file_image.push_back(w[31:24]);
            file_image.push_back(w[23:16]);
            file_image.push_back(w[15:8]);
            file_image.push_back(w[7:0]);
        end else begin
            file_image.push_back(w[7:0]);
            file_image.push_back(w[15:8]);
            file_image.push_back(w[23:16]);
            file_image.push_back(w[31:24]);
        end
    endtask

    task automatic push_record(input logic [WORD_W-1:0] seconds,
                               input logic [WORD_W-1:0] rec_len, input int body_bytes);
        push_word(seconds);
        push_word($urandom);
        push_word(rec_len);
        push_word($urandom);
        repeat (body_bytes) file_image.push_back($urandom_range(255, 0));
    endtask

    task automatic feed(input int count);
        repeat (count) begin
            if (file_image.size() != 0)
                capture_bytes.push_back(file_image.pop_front());
        end
    endtask

    // returns at a clock edge once the stream is drained and the block is quiet
    task automatic settle();
        while (capture_bytes.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == REG_INDEX_ENABLE)
            fr_cfg.index_enable = value;
        else if (index == REG_PAYLOAD_ENABLE)
            fr_cfg.payload_enable = value;
    endtask

    initial begin : main_seq
        file_form_t        form;
        logic [WORD_W-1:0] magic;
        logic [WORD_W-1:0] rec_len;
        int                pick;
        int                spin;
        int                index_plan[5];
        int                payload_plan[5];
        int                idle_plan[5];

        index_plan   = '{0, 1, 0, 1, 1};
        payload_plan = '{1, 0, 0, 1, 1};
        idle_plan    = '{40, 0, 25, 50, 0};

        // one file per run, so the seed picks which magic this run sees
        pick = $urandom_range(3, 0);
        form = (pick == 0) ? FILE_NATIVE : (pick == 1) ? FILE_SWAPPED : FILE_BAD_MAGIC;
        case (form)
            FILE_NATIVE:  magic = MAGIC_NATIVE;
            FILE_SWAPPED: magic = MAGIC_SWAPPED;
            default: begin
                magic = $urandom;
                if ($urandom_range(1, 0))
                    magic = MAGIC_NATIVE ^ (32'h1 << $urandom_range(31, 0));
                while (magic == MAGIC_NATIVE || magic == MAGIC_SWAPPED)
                    magic = $urandom;
            end
        endcase
        file_image.push_back(magic[7:0]);
        file_image.push_back(magic[15:8]);
        file_image.push_back(magic[23:16]);
        file_image.push_back(magic[31:24]);
        repeat (GLOBAL_HDR_LEN - 4) file_image.push_back($urandom_range(255, 0));
        file_swapped = (form == FILE_SWAPPED);

        // directed records: empty record, extreme seconds, single-byte payload
        push_record(32'h0, 32'h0, 0);
        push_record(32'hffffffff, 32'h1, 1);
        push_record($urandom, 32'h3, 3);

        while (file_image.size() < 340) begin
            pick = $urandom_range(99, 0);
            if (pick < 10)
                rec_len = 0;
            else if (pick < 75)
                rec_len = $urandom_range(8, 1);
            else
                rec_len = $urandom_range(40, 9);
            push_record($urandom, rec_len, rec_len);
        end
        // long record at the tail: only its head is ever sent
        rec_len = {1'b1, 31'($urandom)};
        push_record($urandom, rec_len, 24);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_INDEX_ENABLE, 1'($urandom_range(1, 0)));
        write_reg(REG_PAYLOAD_ENABLE, 1'b1);
        cfg_valid <= 1'b0;
        idle_pct = 30;
        feed(GLOBAL_HDR_LEN + 3 * RECORD_HDR_LEN + 4);
        settle();

        for (int p = 0; p < 5; p++) begin
            if (p == 2) begin
                write_reg(STRAY_INDEX, 1'b1);
                write_reg(TOP_INDEX, 1'b1);
            end
            write_reg(REG_INDEX_ENABLE, 1'(index_plan[p]));
            write_reg(REG_PAYLOAD_ENABLE, 1'(payload_plan[p]));
            cfg_valid <= 1'b0;
            idle_pct = idle_plan[p];
            if (p == 4)
                feed(file_image.size());
            else
                feed($urandom_range(110, 60));
            if (p != 4)
                settle();
        end

        while (capture_bytes.size() != 0 || s_tvalid)
            @(posedge aclk);
        for (spin = 0; spin < 2000 && due_results.size() != 0; spin++)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (due_results.size() != 0)
            report_mismatch("results never seen", 64'(due_results.size()), 64'(0));

        if (mismatches == 0)
            $display("pcap_record_framer_top_test OK");
        else
            $display("pcap_record_framer_top_test NOT OK");
        $finish;
    end

endmodule

>>> pcap_record_framer_top.f
src/prf_pkg.sv
src/prf_parser.sv
src/prf_skid.sv
src/pcap_record_framer_top.sv
src/prf_checker.sv
sim/pcap_record_framer_top_test.sv
